### hdl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the even-odd point-in-polygon test.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Default coordinate width, signed centimetres
  localparam int COORD_BITS_DEF = 18;

  // Entries in the queue between the front and back parts
  localparam int QUEUE_DEPTH = 4;

  // Result word: inside flag padded to one byte
  localparam int OUT_TDATA_W = 8;

  // Per-word edge flags handed from front to back.
  // Edge a: current vertex to previous. Edge b: closing edge, first to last.
  typedef struct packed {
    logic span_a;   // edge a crosses the query line
    logic neg_a;    // edge a runs downwards across the query line
    logic span_b;   // edge b crosses the query line
    logic neg_b;    // edge b runs downwards across the query line
    logic last;     // word closes the ring
  } pip_ctl_t;

  localparam int CTL_W = $bits(pip_ctl_t);

endpackage

### hdl/pip_front.sv
// ----------------------------------------------------------------------------
// pip_front
// Accepts vertex words, tracks first and previous vertex, and forms the edge
// span flags and coordinate differences for the back part.
// ----------------------------------------------------------------------------
module pip_front #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
  parameter int DW         = COORD_BITS + 1,
  parameter int TDATA_W    = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [TDATA_W-1:0]   in_data,
  input  logic                 in_last,
  output pip_pkg::pip_ctl_t    ctl,
  output logic [8*DW-1:0]      diffs
);
  import pip_pkg::*;

  logic signed [COORD_BITS-1:0] qx, qy, vx, vy;
  logic signed [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
  logic signed [COORD_BITS-1:0] fx, fy;
  logic                         have_first;
  logic signed [DW-1:0]         qx_e, qy_e, vx_e, vy_e, px_e, py_e, fx_e, fy_e;
  logic signed [DW-1:0]         lhs_a, d_a, dx_a, rhs_a, lhs_b, d_b, dx_b, rhs_b;

  // Unpack the word, first field lowest
  assign qx = in_data[COORD_BITS-1:0];
  assign qy = in_data[2*COORD_BITS-1:COORD_BITS];
  assign vx = in_data[3*COORD_BITS-1:2*COORD_BITS];
  assign vy = in_data[4*COORD_BITS-1:3*COORD_BITS];

  // Closing edge starts at the current vertex when the ring has only one
  assign fx = have_first ? first_x : vx;
  assign fy = have_first ? first_y : vy;

  assign qx_e = {qx[COORD_BITS-1], qx};
  assign qy_e = {qy[COORD_BITS-1], qy};
  assign vx_e = {vx[COORD_BITS-1], vx};
  assign vy_e = {vy[COORD_BITS-1], vy};
  assign px_e = {prev_x[COORD_BITS-1], prev_x};
  assign py_e = {prev_y[COORD_BITS-1], prev_y};
  assign fx_e = {fx[COORD_BITS-1], fx};
  assign fy_e = {fy[COORD_BITS-1], fy};

  // Edge a runs from the current vertex to the previous one
  assign lhs_a = qx_e - vx_e;
  assign d_a   = py_e - vy_e;
  assign dx_a  = px_e - vx_e;
  assign rhs_a = qy_e - vy_e;

  // Edge b runs from the first vertex to the current one
  assign lhs_b = qx_e - fx_e;
  assign d_b   = vy_e - fy_e;
  assign dx_b  = vx_e - fx_e;
  assign rhs_b = qy_e - fy_e;

  // Classify both edges against the query line
  always_comb begin
    ctl.span_a = have_first && ((vy > qy) != (prev_y > qy));
    ctl.neg_a  = vy > qy;
    ctl.span_b = in_last && ((fy > qy) != (vy > qy));
    ctl.neg_b  = fy > qy;
    ctl.last   = in_last;
  end

  assign diffs = {rhs_b, dx_b, d_b, lhs_b, rhs_a, dx_a, d_a, lhs_a};

  // Track ring state; clear it when the ring closes
  always_ff @(posedge clk) begin
    if (rst) begin
      have_first <= 1'b0;
      first_x    <= '0;
      first_y    <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
    end else if (accept) begin
      if (in_last) begin
        have_first <= 1'b0;
        first_x    <= '0;
        first_y    <= '0;
        prev_x     <= '0;
        prev_y     <= '0;
      end else begin
        if (!have_first) begin
          first_x <= vx;
          first_y <= vy;
        end
        have_first <= 1'b1;
        prev_x     <= vx;
        prev_y     <= vy;
      end
    end
  end

endmodule

### hdl/pip_queue.sv
// ----------------------------------------------------------------------------
// pip_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module pip_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = pip_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] pop_data
);
  import pip_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push, do_pop;

  assign not_full  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/pip_back.sv
// ----------------------------------------------------------------------------
// pip_back
// Forms the cross-products of both edges, compares them, folds the toggles
// into the ring parity and presents the result word.
// ----------------------------------------------------------------------------
module pip_back #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
  parameter int DW         = COORD_BITS + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pip_pkg::pip_ctl_t                   in_ctl,
  input  logic [8*DW-1:0]                     in_diffs,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pip_pkg::OUT_TDATA_W-1:0]     out_data
);
  import pip_pkg::*;

  localparam int PRW = 2 * DW;

  logic signed [DW-1:0]  lhs_a, d_a, dx_a, rhs_a, lhs_b, d_b, dx_b, rhs_b;
  logic signed [PRW-1:0] pl_a, pr_a, pl_b, pr_b;
  pip_ctl_t              m_ctl;
  logic                  m_vld, m_adv, tog_a, tog_b, parity, parity_next, inside_flag;

  assign {rhs_b, dx_b, d_b, lhs_b, rhs_a, dx_a, d_a, lhs_a} = in_diffs;

  // Product stage advances unless a closing word meets a stalled result
  assign m_adv    = m_vld && (!m_ctl.last || !out_valid || out_ready);
  assign in_ready = !m_vld || m_adv;

  // Register the four products
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pl_a  <= lhs_a * d_a;
      pr_a  <= dx_a * rhs_a;
      pl_b  <= lhs_b * d_b;
      pr_b  <= dx_b * rhs_b;
      m_ctl <= in_ctl;
    end
  end

  // Compare; a downward edge reverses the sense of the test
  always_comb begin
    tog_a       = m_ctl.span_a && (m_ctl.neg_a ? (pr_a < pl_a) : (pl_a < pr_a));
    tog_b       = m_ctl.span_b && (m_ctl.neg_b ? (pr_b < pl_b) : (pl_b < pr_b));
    parity_next = parity ^ tog_a ^ tog_b;
  end

  // Hold parity across the ring, drop it when the ring closes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld     <= 1'b0;
      parity    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        m_vld <= in_valid;
      end
      if (m_adv) begin
        parity <= m_ctl.last ? 1'b0 : parity_next;
      end
      if (m_adv && m_ctl.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (m_adv && m_ctl.last) begin
      inside_flag <= parity_next;
    end
  end

  assign out_data = {{(OUT_TDATA_W - 1){1'b0}}, inside_flag};

endmodule

### hdl/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd ray-casting point-in-polygon test over a stream of polygon vertices.
//
//  channel  dir  tdata fields (low bit up)                  tlast        tuser
//  s_axis   in   query_x, query_y, vert_x, vert_y           last_vertex  -
//  m_axis   out  inside_res, zero padded to 8 bits          -            -
//
//  One vertex word is accepted every clock while the queue has room; each word
//  drives one pair of edge tests through four multipliers and one compare stage.
//  A closing vertex passes the queue and the product register to the result register.
//  Synchronous reset clears ring state, queue and pipeline; nothing is lost
//  across a stall: the queue holds up to four words while the result waits.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
  parameter int TDATA_W    = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [TDATA_W-1:0]              s_axis_tdata,  // query_x, query_y, vert_x, vert_y
  input  logic                            s_axis_tlast,  // last_vertex
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pip_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // inside_res
);
  import pip_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int QW = 8 * DW + CTL_W;

  pip_ctl_t          f_ctl, b_ctl;
  logic [8*DW-1:0]   f_diffs;
  logic [QW-1:0]     q_out;
  logic              q_not_full, q_not_empty, b_ready, accept;

  assign s_axis_tready = q_not_full;
  assign accept        = s_axis_tvalid && q_not_full;

  // Front: classify each accepted word
  pip_front #(
    .COORD_BITS (COORD_BITS),
    .DW         (DW),
    .TDATA_W    (TDATA_W)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (s_axis_tdata),
    .in_last (s_axis_tlast),
    .ctl     (f_ctl),
    .diffs   (f_diffs)
  );

  // Queue between front and back
  pip_queue #(
    .DATA_W (QW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data ({f_ctl, f_diffs}),
    .not_full  (q_not_full),
    .pop       (b_ready),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  assign b_ctl = q_out[QW-1:8*DW];

  // Back: products, compare, parity, result
  pip_back #(
    .COORD_BITS (COORD_BITS),
    .DW         (DW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_not_empty),
    .in_ready  (b_ready),
    .in_ctl    (b_ctl),
    .in_diffs  (q_out[8*DW-1:0]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

### hdl/pip_checker.sv
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks for the point-in-polygon test, bound to the top level.
// ----------------------------------------------------------------------------
module pip_checker #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
  parameter int TDATA_W    = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [TDATA_W-1:0]              s_axis_tdata,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pip_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import pip_pkg::*;

  logic [7:0] pending;
  logic       in_close, out_take;

  assign in_close = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign out_take = m_axis_tvalid && m_axis_tready;

  // Count closed rings whose result is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_close, out_take})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A result only follows a closed ring
  a_owed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 8'd0)
    else $error("result without a closing vertex");

  // Padding above the inside flag stays zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:1] == '0)
    else $error("result padding not zero");

endmodule

bind point_in_polygon_test pip_checker #(
  .COORD_BITS (COORD_BITS),
  .TDATA_W    (TDATA_W)
) u_pip_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the even-odd point-in-polygon test. Vertex words
// stream in through the s_axis side in bursts with random gaps. A ray-casting
// predictor follows each accepted word and queues the inside flag that every
// closing vertex should produce. The m_axis side stalls on shifting patterns,
// and each result byte is checked against the oldest queued flag.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     COORD_BITS  = pip_pkg::COORD_BITS_DEF;
  localparam int     TDATA_W     = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int     OUT_W       = pip_pkg::OUT_TDATA_W;
  localparam int     CLK_PERIOD  = 20;
  localparam int     RAND_WORDS  = 650;
  localparam int     DRAIN_WAIT  = 8;
  localparam int     CYCLE_LIMIT = 800000;
  localparam longint COORD_HI    = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO    = -(longint'(1) <<< (COORD_BITS - 1));

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // One vertex word waiting to be sent
  typedef struct {
    coord_t qx;
    coord_t qy;
    coord_t vx;
    coord_t vy;
    bit     last;
    bit     drain;  // hold this word back until every result has come
  } vertex_word_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;

  vertex_word_t vertex_q[$];
  bit           inside_exp_q[$];

  // Predictor copy of the ring state
  coord_t ring_first_x = '0;
  coord_t ring_first_y = '0;
  coord_t ring_prev_x  = '0;
  coord_t ring_prev_y  = '0;
  bit     ring_parity  = 1'b0;
  bit     ring_open    = 1'b0;

  bit         word_taken  = 1'b0;
  int         word_cnt    = 0;
  int         burst_left  = 8;
  int         gap_left    = 0;
  logic [7:0] ready_pat   = 8'hFF;
  int         ready_hold  = 0;
  int         cycle_cnt   = 0;
  int         errors      = 0;
  logic [OUT_W-1:0] exp_byte;

  point_in_polygon_test #(
    .COORD_BITS (COORD_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // True when edge a-b spans qy and the query lies strictly left of the crossing.
  // Cross-multiplied so no division is needed; products stay well inside 64 bits.
  function automatic bit edge_crosses(longint ax, longint ay, longint bx, longint by,
                                      longint qx, longint qy);
    longint dy;
    longint rise;
    if ((ay > qy) == (by > qy)) return 1'b0;
    dy   = by - ay;
    rise = qy - ay;
    if (dy < 0) begin
      dy   = -dy;
      rise = -rise;
    end
    return (qx - ax) * dy < (bx - ax) * rise;
  endfunction

  // Advance the ring by one accepted vertex; queue the inside flag on a closing one
  task automatic ring_vertex(coord_t qx, coord_t qy, coord_t vx, coord_t vy, bit last);
    if (!ring_open) begin
      ring_first_x = vx;
      ring_first_y = vy;
      ring_open    = 1'b1;
    end else if (edge_crosses(vx, vy, ring_prev_x, ring_prev_y, qx, qy)) begin
      ring_parity = ~ring_parity;
    end
    ring_prev_x = vx;
    ring_prev_y = vy;
    if (last) begin
      if (edge_crosses(ring_first_x, ring_first_y, vx, vy, qx, qy))
        ring_parity = ~ring_parity;
      inside_exp_q.push_back(ring_parity);
      ring_first_x = '0;
      ring_first_y = '0;
      ring_prev_x  = '0;
      ring_prev_y  = '0;
      ring_parity  = 1'b0;
      ring_open    = 1'b0;
    end
  endtask

  function automatic coord_t clamp_coord(longint v);
    if (v > COORD_HI) return C_MAX;
    if (v < COORD_LO) return C_MIN;
    return coord_t'(v);
  endfunction

  function automatic coord_t coord_near(longint centre, int unsigned radius);
    longint off;
    off = longint'($urandom_range(2 * radius, 0)) - longint'(radius);
    return clamp_coord(centre + off);
  endfunction

  task automatic push_vertex(coord_t qx, coord_t qy, coord_t vx, coord_t vy,
                             bit last, bit drain);
    vertex_word_t w;
    w.qx    = qx;
    w.qy    = qy;
    w.vx    = vx;
    w.vy    = vy;
    w.last  = last;
    w.drain = drain;
    vertex_q.push_back(w);
    word_cnt++;
  endtask

  // Queue a ring of n vertices scattered around a centre; the query may wander
  task automatic push_ring(int n, int unsigned radius, bit wander);
    longint cx;
    longint cy;
    coord_t qx;
    coord_t qy;
    coord_t vx;
    coord_t vy;
    bit     drain;
    cx = longint'(coord_t'($urandom));
    cy = longint'(coord_t'($urandom));
    qx = coord_near(cx, radius);
    qy = coord_near(cy, radius);
    drain = ($urandom_range(0, 29) == 0);
    for (int i = 0; i < n; i++) begin
      if (wander && $urandom_range(0, 2) == 0) begin
        qx = coord_near(cx, radius);
        qy = coord_near(cy, radius);
      end
      // level with the query now and then, to hit the span boundary
      vy = ($urandom_range(0, 3) == 0) ? qy : coord_near(cy, radius);
      vx = ($urandom_range(0, 7) == 0) ? qx : coord_near(cx, radius);
      push_vertex(qx, qy, vx, vy, i == n - 1, drain && i == 0);
    end
  endtask

  // Stimulus, then wait for the pipeline to empty
  initial begin
    int          sel;
    int          n;
    int unsigned radius;

    // lone vertex, and a two-vertex ring: both outside
    push_vertex(0, 0, 5, 5, 1'b1, 1'b0);
    push_vertex(0, 0, -10, -10, 1'b0, 1'b0);
    push_vertex(0, 0, 10, 10, 1'b1, 1'b0);
    // full-range triangle around the origin
    push_vertex(0, 0, C_MIN, C_MIN, 1'b0, 1'b0);
    push_vertex(0, 0, C_MAX, C_MIN, 1'b0, 1'b0);
    push_vertex(0, 0, 0, C_MAX, 1'b1, 1'b0);
    // full-range square, query on its top-left corner
    push_vertex(C_MIN, C_MAX, C_MIN, C_MIN, 1'b0, 1'b0);
    push_vertex(C_MIN, C_MAX, C_MAX, C_MIN, 1'b0, 1'b0);
    push_vertex(C_MIN, C_MAX, C_MAX, C_MAX, 1'b0, 1'b0);
    push_vertex(C_MIN, C_MAX, C_MIN, C_MAX, 1'b1, 1'b0);
    // query level with a vertex, sent only once the pipeline is empty
    push_vertex(0, 0, -5, 0, 1'b0, 1'b1);
    push_vertex(0, 0, 5, -5, 1'b0, 1'b0);
    push_vertex(0, 0, 5, 5, 1'b1, 1'b0);
    // query moving within one ring
    push_vertex(-1, -1, -20, -20, 1'b0, 1'b0);
    push_vertex(3, 3, 20, -20, 1'b0, 1'b0);
    push_vertex(-1, 2, 20, 20, 1'b0, 1'b0);
    push_vertex(C_MAX, 0, -20, 20, 1'b1, 1'b0);
    // query right of a triangle
    push_vertex(50, 0, -5, -5, 1'b0, 1'b0);
    push_vertex(50, 0, 5, -5, 1'b0, 1'b0);
    push_vertex(50, 0, 0, 10, 1'b1, 1'b0);
    // all-ones query inside a small triangle
    push_vertex(-1, -1, -3, -2, 1'b0, 1'b0);
    push_vertex(-1, -1, 2, -3, 1'b0, 1'b0);
    push_vertex(-1, -1, 0, 4, 1'b1, 1'b0);

    // random rings, mostly well formed
    n = word_cnt;
    while (word_cnt < n + RAND_WORDS) begin
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0:       radius = 8;
        1:       radius = 100;
        2:       radius = 5000;
        default: radius = 140000;
      endcase
      if (sel < 65)
        push_ring(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(3, 8),
                  radius, 1'b0);
      else if (sel < 75)
        push_ring($urandom_range(1, 2), radius, 1'b0);
      else if (sel < 88)
        push_ring($urandom_range(3, 10), radius, 1'b1);
      else
        push_ring($urandom_range(3, 8), 140000, 1'b0);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (vertex_q.size() != 0 || inside_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  // Sender: bursts of words with random gaps between them
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || word_taken) begin
      if (word_taken) begin
        vertex_q.delete(0);
        word_taken = 1'b0;
      end
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (vertex_q.size() == 0 || (vertex_q[0].drain && inside_exp_q.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'({vertex_q[0].vy, vertex_q[0].vx,
                                   vertex_q[0].qy, vertex_q[0].qx});
        s_axis_tlast  <= vertex_q[0].last;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 20);
        end
      end
    end
  end

  // Receiver: rotate a stall pattern, reloading it every so often
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      case ($urandom_range(0, 2))
        0:       ready_pat = 8'hFF;
        1:       ready_pat = 8'($urandom) | 8'h01;
        default: ready_pat = 8'h01 << $urandom_range(0, 7);
      endcase
      ready_hold = $urandom_range(20, 200);
    end else begin
      ready_hold--;
    end
    ready_pat = {ready_pat[0], ready_pat[7:1]};
    m_axis_tready <= ready_pat[0];
  end

  // Monitor: predict on accepted vertex words, check accepted result words
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("tb failed");
      $finish;
    end else if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        word_taken = 1'b1;
        ring_vertex(s_axis_tdata[0 +: COORD_BITS],
                    s_axis_tdata[COORD_BITS +: COORD_BITS],
                    s_axis_tdata[2 * COORD_BITS +: COORD_BITS],
                    s_axis_tdata[3 * COORD_BITS +: COORD_BITS],
                    s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (inside_exp_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          exp_byte = OUT_W'(inside_exp_q.pop_front());
          if (m_axis_tdata !== exp_byte) begin
            $display("%0t: inside_res mismatch, expected %h, got %h",
                     $time, exp_byte, m_axis_tdata);
            errors++;
          end
        end
      end
    end
  end

endmodule

### filelist.f
hdl/pip_pkg.sv
hdl/pip_front.sv
hdl/pip_queue.sv
hdl/pip_back.sv
hdl/point_in_polygon_test.sv
hdl/pip_checker.sv
dv/tb.sv
